[rtl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Types and codes shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int DefTableDepth = 16;

   localparam int IdWidth   = 8;
   localparam int RemWidth  = 16;
   localparam int PrioWidth = 8;

   // request kinds
   localparam logic KIND_ARRIVE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO_BURST = 2'd2;

   typedef struct packed {
      logic [IdWidth-1:0]   id;
      logic [RemWidth-1:0]  rem;
      logic [PrioWidth-1:0] prio;
   } entry_type;

endpackage

[rtl/preemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Event driven preemptive priority scheduler with a scanned ready table.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered by exactly one response
// word. An idle tick, a tick that leaves work remaining, a zero-burst arrival
// and an arrival on an idle CPU pass from DECIDE straight to RESP. An arrival
// on a busy CPU, and a tick that finishes the running process, walk the ready
// table through its single read port and one shared priority comparator, one
// slot per cycle, then pass through APPLY to RESP. The response sits in an
// output register; req_ready is high only while the sequencer is idle, and a
// response waiting on rsp_ready holds the sequencer before it loads the next
// one.
module preemptive_priority_scheduler
#(
   parameter int TABLE_DEPTH = pps_pkg::DefTableDepth
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [pps_pkg::IdWidth-1:0]    req_proc_id,
   input  logic [pps_pkg::RemWidth-1:0]   req_burst_len,
   input  logic [pps_pkg::PrioWidth-1:0]  req_prio_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_cpu_busy,
   output logic [pps_pkg::IdWidth-1:0]    rsp_running_id,
   output logic                           rsp_switched,
   output logic                           rsp_finished,
   output logic [pps_pkg::IdWidth-1:0]    rsp_finished_id,
   output logic [1:0]                     rsp_status
);
   import pps_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_APPLY  = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0] state_ff, state_in;

   // latched request
   logic                 rq_kind_ff, rq_kind_in;
   logic [IdWidth-1:0]   rq_id_ff, rq_id_in;
   logic [RemWidth-1:0]  rq_blen_ff, rq_blen_in;
   logic [PrioWidth-1:0] rq_prio_ff, rq_prio_in;

   // running process
   logic      cur_valid_ff, cur_valid_in;
   entry_type cur_ff, cur_in;

   // ready table: valid bits in flops, payload in memory
   logic [TABLE_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   entry_type              mem [TABLE_DEPTH];
   logic                   mem_we;
   logic [IW-1:0]          mem_waddr;
   entry_type              mem_wdata;
   entry_type              rd_data_ff;

   // scan pipeline
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_slot_vld_ff, rd_slot_vld_in;

   logic                 free_found_ff, free_found_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic                 best_found_ff, best_found_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   entry_type            best_ff, best_in;

   // staged result flags
   logic               sw_ff, sw_in;
   logic               fin_ff, fin_in;
   logic [IdWidth-1:0] fin_id_ff, fin_id_in;
   logic [1:0]         status_ff, status_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_busy_ff, rsp_busy_in;
   logic [IdWidth-1:0] rsp_run_id_ff, rsp_run_id_in;
   logic               rsp_sw_ff, rsp_sw_in;
   logic               rsp_fin_ff, rsp_fin_in;
   logic [IdWidth-1:0] rsp_fin_id_ff, rsp_fin_id_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   entry_type arriving;

   always_comb begin
      arriving.id   = rq_id_ff;
      arriving.rem  = rq_blen_ff;
      arriving.prio = rq_prio_ff;

      state_in       = state_ff;
      rq_kind_in     = rq_kind_ff;
      rq_id_in       = rq_id_ff;
      rq_blen_in     = rq_blen_ff;
      rq_prio_in     = rq_prio_ff;
      cur_valid_in   = cur_valid_ff;
      cur_in         = cur_ff;
      slot_valid_in  = slot_valid_ff;
      cnt_in         = cnt_ff;
      rd_pend_in     = 1'b0;
      rd_idx_in      = rd_idx_ff;
      rd_slot_vld_in = rd_slot_vld_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      sw_in          = sw_ff;
      fin_in         = fin_ff;
      fin_id_in      = fin_id_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_busy_in    = rsp_busy_ff;
      rsp_run_id_in  = rsp_run_id_ff;
      rsp_sw_in      = rsp_sw_ff;
      rsp_fin_in     = rsp_fin_ff;
      rsp_fin_id_in  = rsp_fin_id_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = free_idx_ff;
      mem_wdata      = arriving;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rq_kind_in = req_kind;
               rq_id_in   = req_proc_id;
               rq_blen_in = req_burst_len;
               rq_prio_in = req_prio_level;
               state_in   = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            sw_in         = 1'b0;
            fin_in        = 1'b0;
            fin_id_in     = '0;
            status_in     = STATUS_OK;
            cnt_in        = '0;
            free_found_in = 1'b0;
            best_found_in = 1'b0;
            state_in      = ST_RESP;
            if (rq_kind_ff == KIND_ARRIVE) begin
               if (rq_blen_ff == '0) begin
                  status_in = STATUS_ZERO_BURST;
               end else if (!cur_valid_ff) begin
                  cur_valid_in = 1'b1;
                  cur_in       = arriving;
                  sw_in        = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end else if (cur_valid_ff) begin
               cur_in.rem = cur_ff.rem - RemWidth'(1);
               if (cur_ff.rem == RemWidth'(1)) begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (cnt_ff != CW'(TABLE_DEPTH)) begin
               rd_pend_in     = 1'b1;
               rd_idx_in      = cnt_ff[IW-1:0];
               rd_slot_vld_in = slot_valid_ff[cnt_ff[IW-1:0]];
               cnt_in         = cnt_ff + CW'(1);
            end else begin
               state_in = ST_APPLY;
            end
            // shared compare on the word read last cycle
            if (rd_pend_ff) begin
               if (!rd_slot_vld_ff && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (rd_slot_vld_ff && (!best_found_ff || rd_data_ff.prio < best_ff.prio)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_in       = rd_data_ff;
               end
            end
         end

         ST_APPLY: begin
            state_in = ST_RESP;
            if (rq_kind_ff == KIND_ARRIVE) begin
               if (!free_found_ff) begin
                  status_in = STATUS_TABLE_FULL;
               end else begin
                  mem_we                     = 1'b1;
                  slot_valid_in[free_idx_ff] = 1'b1;
                  if (rq_prio_ff < cur_ff.prio) begin
                     // preempt: running process goes back to the table
                     mem_wdata = cur_ff;
                     cur_in    = arriving;
                     sw_in     = 1'b1;
                  end
               end
            end else begin
               fin_in    = 1'b1;
               fin_id_in = cur_ff.id;
               if (best_found_ff) begin
                  cur_in                     = best_ff;
                  slot_valid_in[best_idx_ff] = 1'b0;
                  sw_in                      = 1'b1;
               end else begin
                  cur_valid_in = 1'b0;
               end
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_busy_in   = cur_valid_ff;
               rsp_run_id_in = cur_valid_ff ? cur_ff.id : '0;
               rsp_sw_in     = sw_ff;
               rsp_fin_in    = fin_ff;
               rsp_fin_id_in = fin_id_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_valid_ff  <= cur_valid_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_pend_ff    <= rd_pend_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rq_kind_ff     <= rq_kind_in;
      rq_id_ff       <= rq_id_in;
      rq_blen_ff     <= rq_blen_in;
      rq_prio_ff     <= rq_prio_in;
      cur_ff         <= cur_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      rd_slot_vld_ff <= rd_slot_vld_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_ff        <= best_in;
      sw_ff          <= sw_in;
      fin_ff         <= fin_in;
      fin_id_ff      <= fin_id_in;
      status_ff      <= status_in;
      rsp_busy_ff    <= rsp_busy_in;
      rsp_run_id_ff  <= rsp_run_id_in;
      rsp_sw_ff      <= rsp_sw_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_fin_id_ff  <= rsp_fin_id_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // ready table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[cnt_ff[IW-1:0]];
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cpu_busy    = rsp_busy_ff;
   assign rsp_running_id  = rsp_run_id_ff;
   assign rsp_switched    = rsp_sw_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_finished_id = rsp_fin_id_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
